FILE: rtl/core/tcc_pkg.sv
// Shared widths, codes and bundle types of the text console cursor and scroll engine.
`timescale 1ns / 1ps

package tcc_pkg;

    localparam int COL_W      = 8;
    localparam int LINE_W     = 10;
    localparam int CH_W       = 8;
    localparam int FUNC_W     = 3;
    localparam int KIND_W     = 3;
    localparam int COLOUR_W   = 32;
    localparam int COLS_W     = 9;
    localparam int LINES_W    = 11;
    localparam int TAB_W      = 4;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int TDATA_W    = 64;

    localparam logic [COLS_W-1:0]  MAX_COLUMNS     = COLS_W'(256);
    localparam logic [LINES_W-1:0] MAX_STORE_LINES = LINES_W'(1024);
    localparam logic [TAB_W-1:0]   MAX_TAB         = TAB_W'(8);

    localparam logic [COLS_W-1:0]   COLUMNS_RST    = COLS_W'(80);
    localparam logic [LINES_W-1:0]  VISIBLE_RST    = LINES_W'(25);
    localparam logic [LINES_W-1:0]  STORE_RST      = LINES_W'(1024);
    localparam logic [TAB_W-1:0]    TAB_RST        = TAB_W'(4);
    localparam logic [COLOUR_W-1:0] BACKGROUND_RST = '0;

    localparam logic [CH_W-1:0] CH_BS  = 8'h08;
    localparam logic [CH_W-1:0] CH_TAB = 8'h09;
    localparam logic [CH_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CH_W-1:0] CH_CR  = 8'h0D;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUT       = 3'd0,
        FUNC_VIEW_UP   = 3'd1,
        FUNC_VIEW_DOWN = 3'd2,
        FUNC_CLEAR     = 3'd3,
        FUNC_MOVE      = 3'd4
    } func_t;

    typedef enum logic [KIND_W-1:0] {
        K_GLYPH  = 3'd0,
        K_FILL   = 3'd1,
        K_REDRAW = 3'd2,
        K_CURSOR = 3'd3,
        K_CLEAR  = 3'd4,
        K_ERROR  = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        REG_COLUMNS    = 3'd0,
        REG_VISIBLE    = 3'd1,
        REG_STORE      = 3'd2,
        REG_TAB        = 3'd3,
        REG_BACKGROUND = 3'd4
    } reg_addr_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_ADV,
        SEQ_DRAW,
        SEQ_CURSOR
    } seq_state_t;

    // Effective (saturated) configuration.
    typedef struct packed {
        logic [COLS_W-1:0]   cols;
        logic [LINES_W-1:0]  vis;
        logic [LINES_W-1:0]  store;
        logic [TAB_W-1:0]    tab;
        logic [COLOUR_W-1:0] background;
    } cfg_t;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [CH_W-1:0]     ch;
        logic [COL_W-1:0]    target_col;
        logic [LINE_W-1:0]   target_line;
        logic [COLOUR_W-1:0] fill_colour;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [CH_W-1:0]     glyph;
        logic [COL_W-1:0]    col;
        logic [LINE_W-1:0]   row;
        logic [COLOUR_W-1:0] colour;
        logic                last;
    } result_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [LINE_W-1:0] rem;
    } norm_stat_t;

endpackage

FILE: rtl/core/text_console_cursor_scroll.sv
// A request accepted on s_ passes the input holding register and the result register before reaching m_.
// Throughput: one command per cycle from the sequencer while m_tready does not stall it; a request
// may also have silent steps that give no command (view moves, a newline that shifts the view).
// Reset: synchronous, active low; clears cursor, head, view and restores register defaults.
// A write to store_lines reduces the ring head modulo the new store size; no request starts meanwhile.
`timescale 1ns / 1ps

module text_console_cursor_scroll (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tcc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tcc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tcc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // ch[7:0], target_col[15:8], target_line[25:16], fill_colour[57:26], zero above
    input  logic [tcc_pkg::TDATA_W-1:0]        s_tdata,
    // func[2:0]
    input  logic [tcc_pkg::FUNC_W-1:0]         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // glyph[7:0], col[15:8], row[25:16], colour[57:26], zero above
    output logic [tcc_pkg::TDATA_W-1:0]        m_tdata,
    // kind[2:0]
    output logic [tcc_pkg::KIND_W-1:0]         m_tuser,
    output logic                               m_tlast
);

    localparam int PAD_W = tcc_pkg::TDATA_W - tcc_pkg::CH_W - tcc_pkg::COL_W
                         - tcc_pkg::LINE_W - tcc_pkg::COLOUR_W;

    tcc_pkg::cfg_t               cfg;
    tcc_pkg::norm_stat_t         norm;
    tcc_pkg::item_t              item_reg;
    tcc_pkg::result_t            res;
    logic                        in_valid_reg;
    logic                        take;
    logic                        store_wr;
    logic [tcc_pkg::LINE_W-1:0]  head;

    tcc_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cfg      (cfg),
        .store_wr (store_wr)
    );

    tcc_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (store_wr),
        .head_in (head),
        .store   (cfg.store),
        .stat    (norm)
    );

    // Input holding register: a new request is taken as soon as the sequencer empties it.
    assign s_tready = !in_valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                in_valid_reg <= 1'b0;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.func        <= s_tuser;
            item_reg.ch          <= s_tdata[7:0];
            item_reg.target_col  <= s_tdata[15:8];
            item_reg.target_line <= s_tdata[25:16];
            item_reg.fill_colour <= s_tdata[57:26];
        end
    end

    tcc_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .norm       (norm),
        .item       (item_reg),
        .item_valid (in_valid_reg),
        .take       (take),
        .m_tready   (m_tready),
        .m_valid    (m_tvalid),
        .res        (res),
        .head       (head)
    );

    assign m_tdata = {{PAD_W{1'b0}}, res.colour, res.row, res.col, res.glyph};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

FILE: rtl/core/tcc_cfg.sv
// Configuration register file with APB-style access and saturation of the used values.
`timescale 1ns / 1ps

module tcc_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tcc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tcc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tcc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output tcc_pkg::cfg_t                     cfg,
    output logic                              store_wr
);

    logic [tcc_pkg::COLS_W-1:0]   columns_reg;
    logic [tcc_pkg::LINES_W-1:0]  visible_reg;
    logic [tcc_pkg::LINES_W-1:0]  store_reg;
    logic [tcc_pkg::TAB_W-1:0]    tab_reg;
    logic [tcc_pkg::COLOUR_W-1:0] background_reg;

    logic                  wr_en;
    tcc_pkg::reg_addr_t    addr;
    logic [tcc_pkg::LINES_W-1:0] store_eff;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign addr   = tcc_pkg::reg_addr_t'(paddr[tcc_pkg::APB_ADDR_W-1:2]);
    assign store_wr = wr_en && (addr == tcc_pkg::REG_STORE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg    <= tcc_pkg::COLUMNS_RST;
            visible_reg    <= tcc_pkg::VISIBLE_RST;
            store_reg      <= tcc_pkg::STORE_RST;
            tab_reg        <= tcc_pkg::TAB_RST;
            background_reg <= tcc_pkg::BACKGROUND_RST;
        end else if (wr_en) begin
            unique case (addr)
                tcc_pkg::REG_COLUMNS:    columns_reg    <= pwdata[tcc_pkg::COLS_W-1:0];
                tcc_pkg::REG_VISIBLE:    visible_reg    <= pwdata[tcc_pkg::LINES_W-1:0];
                tcc_pkg::REG_STORE:      store_reg      <= pwdata[tcc_pkg::LINES_W-1:0];
                tcc_pkg::REG_TAB:        tab_reg        <= pwdata[tcc_pkg::TAB_W-1:0];
                tcc_pkg::REG_BACKGROUND: background_reg <= pwdata[tcc_pkg::COLOUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (addr)
            tcc_pkg::REG_COLUMNS:    prdata = tcc_pkg::APB_DATA_W'(columns_reg);
            tcc_pkg::REG_VISIBLE:    prdata = tcc_pkg::APB_DATA_W'(visible_reg);
            tcc_pkg::REG_STORE:      prdata = tcc_pkg::APB_DATA_W'(store_reg);
            tcc_pkg::REG_TAB:        prdata = tcc_pkg::APB_DATA_W'(tab_reg);
            tcc_pkg::REG_BACKGROUND: prdata = tcc_pkg::APB_DATA_W'(background_reg);
            default:                 prdata = '0;
        endcase
    end

    // The visible window is clamped to the clamped store size.
    always_comb begin
        if (store_reg == '0) begin
            store_eff = tcc_pkg::LINES_W'(1);
        end else if (store_reg > tcc_pkg::MAX_STORE_LINES) begin
            store_eff = tcc_pkg::MAX_STORE_LINES;
        end else begin
            store_eff = store_reg;
        end

        cfg.store = store_eff;

        if (columns_reg == '0) begin
            cfg.cols = tcc_pkg::COLS_W'(1);
        end else if (columns_reg > tcc_pkg::MAX_COLUMNS) begin
            cfg.cols = tcc_pkg::MAX_COLUMNS;
        end else begin
            cfg.cols = columns_reg;
        end

        if (visible_reg == '0) begin
            cfg.vis = tcc_pkg::LINES_W'(1);
        end else if (visible_reg > store_eff) begin
            cfg.vis = store_eff;
        end else begin
            cfg.vis = visible_reg;
        end

        cfg.tab        = (tab_reg > tcc_pkg::MAX_TAB) ? tcc_pkg::MAX_TAB : tab_reg;
        cfg.background = background_reg;
    end

endmodule

FILE: rtl/core/tcc_norm.sv
// Bit-serial remainder unit that reduces the ring head modulo a newly written store size.
`timescale 1ns / 1ps

module tcc_norm (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [tcc_pkg::LINE_W-1:0]       head_in,
    input  logic [tcc_pkg::LINES_W-1:0]      store,
    output tcc_pkg::norm_stat_t              stat
);

    localparam int STEPS = tcc_pkg::LINE_W;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic                         busy_reg;
    logic                         done_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [tcc_pkg::LINE_W-1:0]   rem_reg;
    logic [tcc_pkg::LINE_W-1:0]   div_reg;
    logic [tcc_pkg::LINE_W-1:0]   rem_next;
    logic [tcc_pkg::LINES_W-1:0]  trial;
    logic [tcc_pkg::LINES_W-1:0]  diff;

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    always_comb begin
        trial = {rem_reg, div_reg[tcc_pkg::LINE_W-1]};
        diff  = trial - store;
        rem_next = (trial >= store) ? diff[tcc_pkg::LINE_W-1:0] : trial[tcc_pkg::LINE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            div_reg <= head_in;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            div_reg <= {div_reg[tcc_pkg::LINE_W-2:0], 1'b0};
        end
    end

    assign stat.busy = busy_reg || done_reg;
    assign stat.done = done_reg;
    assign stat.rem  = rem_reg;

endmodule

FILE: rtl/core/tcc_seq.sv
// Command sequencer: console state, one step per cycle unless m_tready stalls the output, and the result register.
`timescale 1ns / 1ps

module tcc_seq (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tcc_pkg::cfg_t               cfg,
    input  tcc_pkg::norm_stat_t         norm,
    input  tcc_pkg::item_t              item,
    input  logic                        item_valid,
    output logic                        take,
    input  logic                        m_tready,
    output logic                        m_valid,
    output tcc_pkg::result_t            res,
    output logic [tcc_pkg::LINE_W-1:0]  head
);

    typedef enum logic [1:0] {
        RET_DONE,
        RET_CURSOR,
        RET_ADV
    } ret_t;

    typedef struct packed {
        logic                        emit;
        tcc_pkg::result_t            res;
        logic [tcc_pkg::COL_W-1:0]   col;
        logic [tcc_pkg::LINE_W-1:0]  line;
        logic [tcc_pkg::LINE_W-1:0]  head;
        logic [tcc_pkg::LINE_W-1:0]  vo;
        logic [tcc_pkg::TAB_W-1:0]   cnt;
        tcc_pkg::seq_state_t         state;
        ret_t                        ret;
    } step_t;

    tcc_pkg::seq_state_t         state_reg;
    ret_t                        ret_reg;
    logic [tcc_pkg::TAB_W-1:0]   cnt_reg;
    logic [tcc_pkg::COL_W-1:0]   col_reg;
    logic [tcc_pkg::LINE_W-1:0]  line_reg;
    logic [tcc_pkg::LINE_W-1:0]  head_reg;
    logic [tcc_pkg::LINE_W-1:0]  vo_reg;
    logic                        m_valid_reg;
    tcc_pkg::result_t            res_reg;

    step_t cur;
    step_t st;
    logic  go;
    logic  fire;

    function automatic tcc_pkg::result_t make_res(
        input tcc_pkg::kind_t              kind,
        input logic [tcc_pkg::CH_W-1:0]    glyph,
        input logic [tcc_pkg::COL_W-1:0]   col,
        input logic [tcc_pkg::LINE_W-1:0]  row,
        input logic [tcc_pkg::COLOUR_W-1:0] colour,
        input logic                        last
    );
        tcc_pkg::result_t r;
        r.kind   = kind;
        r.glyph  = glyph;
        r.col    = col;
        r.row    = row;
        r.colour = colour;
        r.last   = last;
        return r;
    endfunction

    // First shown line that keeps the given line inside the window.
    function automatic logic [tcc_pkg::LINE_W-1:0] follow_line(
        input logic [tcc_pkg::LINE_W-1:0] line,
        input tcc_pkg::cfg_t              c
    );
        logic [tcc_pkg::LINES_W:0] n;
        logic [tcc_pkg::LINES_W:0] ext_line;
        ext_line = (tcc_pkg::LINES_W + 1)'(line);
        if (ext_line >= (tcc_pkg::LINES_W + 1)'(c.vis)) begin
            n = ext_line - (tcc_pkg::LINES_W + 1)'(c.vis) + 1'b1;
        end else begin
            n = '0;
        end
        if (n + (tcc_pkg::LINES_W + 1)'(c.vis) > (tcc_pkg::LINES_W + 1)'(c.store)) begin
            if (c.store > c.vis) begin
                n = (tcc_pkg::LINES_W + 1)'(c.store) - (tcc_pkg::LINES_W + 1)'(c.vis) - 1'b1;
            end else begin
                n = '0;
            end
        end
        return n[tcc_pkg::LINE_W-1:0];
    endfunction

    // Redraw of the window, or an error when the window at that offset would reach beyond the store.
    function automatic tcc_pkg::result_t draw_res(
        input logic [tcc_pkg::LINE_W-1:0] vo,
        input logic [tcc_pkg::LINE_W-1:0] hd,
        input tcc_pkg::cfg_t              c,
        input logic                       last
    );
        logic [tcc_pkg::LINES_W-1:0] sum;
        logic [tcc_pkg::LINES_W-1:0] row;
        sum = tcc_pkg::LINES_W'(vo) + tcc_pkg::LINES_W'(hd);
        row = (sum >= c.store) ? sum - c.store : sum;
        if (tcc_pkg::LINES_W'(vo) > c.store - c.vis) begin
            return make_res(tcc_pkg::K_ERROR, '0, '0, '0, '0, last);
        end
        return make_res(tcc_pkg::K_REDRAW, '0, '0, row[tcc_pkg::LINE_W-1:0], '0, last);
    endfunction

    function automatic step_t newline_step(
        input step_t                     s0,
        input logic [tcc_pkg::TAB_W-1:0] cnt_after,
        input tcc_pkg::cfg_t             c
    );
        step_t                        s;
        logic [tcc_pkg::LINES_W-1:0]  next_line;
        logic [tcc_pkg::LINES_W-1:0]  last_line;
        logic [tcc_pkg::LINES_W-1:0]  head_inc;
        logic [tcc_pkg::LINE_W-1:0]   f;
        s         = s0;
        s.col     = '0;
        s.cnt     = cnt_after;
        s.emit    = 1'b0;
        next_line = tcc_pkg::LINES_W'(s0.line) + 1'b1;
        last_line = c.store - 1'b1;
        head_inc  = tcc_pkg::LINES_W'(s0.head) + 1'b1;
        if (next_line >= c.store) begin
            // Off the end of the store: recycle the head row and always redraw.
            s.line  = last_line[tcc_pkg::LINE_W-1:0];
            s.head  = (head_inc == c.store) ? '0 : head_inc[tcc_pkg::LINE_W-1:0];
            s.vo    = follow_line(last_line[tcc_pkg::LINE_W-1:0], c);
            s.emit  = 1'b1;
            s.res   = make_res(tcc_pkg::K_FILL, '0, '0, s0.head, c.background, 1'b0);
            s.state = tcc_pkg::SEQ_DRAW;
            s.ret   = RET_CURSOR;
        end else begin
            s.line = next_line[tcc_pkg::LINE_W-1:0];
            f      = follow_line(next_line[tcc_pkg::LINE_W-1:0], c);
            if (f != s0.vo) begin
                s.vo    = f;
                s.state = tcc_pkg::SEQ_DRAW;
                s.ret   = RET_CURSOR;
            end else begin
                s.emit  = 1'b1;
                s.res   = make_res(tcc_pkg::K_CURSOR, '0, '0, next_line[tcc_pkg::LINE_W-1:0],
                                   '0, cnt_after == '0);
                s.state = (cnt_after != '0) ? tcc_pkg::SEQ_ADV : tcc_pkg::SEQ_IDLE;
            end
        end
        return s;
    endfunction

    function automatic step_t advance_step(
        input step_t                     s0,
        input logic [tcc_pkg::TAB_W-1:0] cnt_after,
        input tcc_pkg::cfg_t             c
    );
        step_t                       s;
        logic [tcc_pkg::COLS_W-1:0]  next_col;
        logic [tcc_pkg::LINE_W-1:0]  f;
        next_col = tcc_pkg::COLS_W'(s0.col) + 1'b1;
        if (next_col >= c.cols) begin
            return newline_step(s0, cnt_after, c);
        end
        s      = s0;
        s.col  = next_col[tcc_pkg::COL_W-1:0];
        s.cnt  = cnt_after;
        s.emit = 1'b1;
        f      = follow_line(s0.line, c);
        if (f != s0.vo) begin
            s.vo    = f;
            s.res   = make_res(tcc_pkg::K_CURSOR, '0, next_col[tcc_pkg::COL_W-1:0], s0.line,
                               '0, 1'b0);
            s.state = tcc_pkg::SEQ_DRAW;
            s.ret   = RET_ADV;
        end else begin
            s.res   = make_res(tcc_pkg::K_CURSOR, '0, next_col[tcc_pkg::COL_W-1:0], s0.line,
                               '0, cnt_after == '0);
            s.state = (cnt_after != '0) ? tcc_pkg::SEQ_ADV : tcc_pkg::SEQ_IDLE;
        end
        return s;
    endfunction

    // First step of a new request, taken straight from the input register.
    function automatic step_t start_step(
        input step_t          s0,
        input tcc_pkg::item_t it,
        input tcc_pkg::cfg_t  c
    );
        step_t                        s;
        logic [tcc_pkg::LINES_W:0]    reach;
        logic [tcc_pkg::COLS_W-1:0]   last_col;
        logic [tcc_pkg::LINE_W-1:0]   f;
        logic                         bad;
        s        = s0;
        s.emit   = 1'b0;
        s.state  = tcc_pkg::SEQ_IDLE;
        s.ret    = RET_DONE;
        s.cnt    = '0;
        reach    = (tcc_pkg::LINES_W + 1)'(s0.vo) + (tcc_pkg::LINES_W + 1)'(c.vis) + 1'b1;
        last_col = c.cols - 1'b1;
        bad      = (tcc_pkg::COLS_W'(it.target_col) >= c.cols)
                || (tcc_pkg::LINES_W'(it.target_line) >= c.store);
        f        = follow_line(it.target_line, c);
        unique case (it.func)
            tcc_pkg::FUNC_PUT: begin
                case (it.ch) inside
                    tcc_pkg::CH_BS: begin
                        if (s0.col != '0) begin
                            s.col = s0.col - 1'b1;
                        end else if (s0.line != '0) begin
                            s.col  = last_col[tcc_pkg::COL_W-1:0];
                            s.line = s0.line - 1'b1;
                        end
                        s.emit = 1'b1;
                        s.res  = make_res(tcc_pkg::K_CURSOR, '0, s.col, s.line, '0, 1'b1);
                    end
                    tcc_pkg::CH_TAB: begin
                        if (c.tab != '0) begin
                            s = advance_step(s0, c.tab - 1'b1, c);
                        end
                    end
                    tcc_pkg::CH_CR, tcc_pkg::CH_LF: begin
                        s = newline_step(s0, '0, c);
                    end
                    default: begin
                        s.emit  = 1'b1;
                        s.res   = make_res(tcc_pkg::K_GLYPH, it.ch, s0.col, s0.line, '0, 1'b0);
                        s.cnt   = tcc_pkg::TAB_W'(1);
                        s.state = tcc_pkg::SEQ_ADV;
                    end
                endcase
            end
            tcc_pkg::FUNC_VIEW_UP: begin
                if (s0.vo != '0) begin
                    s.vo    = s0.vo - 1'b1;
                    s.state = tcc_pkg::SEQ_DRAW;
                end
            end
            tcc_pkg::FUNC_VIEW_DOWN: begin
                if (reach <= (tcc_pkg::LINES_W + 1)'(c.store)) begin
                    s.vo    = s0.vo + 1'b1;
                    s.state = tcc_pkg::SEQ_DRAW;
                end
            end
            tcc_pkg::FUNC_CLEAR: begin
                s.emit  = 1'b1;
                s.res   = make_res(tcc_pkg::K_CLEAR, '0, '0, '0, it.fill_colour, 1'b0);
                s.col   = '0;
                s.line  = '0;
                s.vo    = '0;
                s.state = tcc_pkg::SEQ_DRAW;
                s.ret   = RET_CURSOR;
            end
            tcc_pkg::FUNC_MOVE: begin
                s.emit = 1'b1;
                if (bad) begin
                    s.res = make_res(tcc_pkg::K_ERROR, '0, '0, '0, '0, 1'b1);
                end else begin
                    s.col  = it.target_col;
                    s.line = it.target_line;
                    if (f != s0.vo) begin
                        s.vo    = f;
                        s.res   = make_res(tcc_pkg::K_CURSOR, '0, it.target_col, it.target_line,
                                           '0, 1'b0);
                        s.state = tcc_pkg::SEQ_DRAW;
                    end else begin
                        s.res = make_res(tcc_pkg::K_CURSOR, '0, it.target_col, it.target_line,
                                         '0, 1'b1);
                    end
                end
            end
            default: begin
                s.emit = 1'b1;
                s.res  = make_res(tcc_pkg::K_ERROR, '0, '0, '0, '0, 1'b1);
            end
        endcase
        return s;
    endfunction

    always_comb begin
        cur       = '0;
        cur.col   = col_reg;
        cur.line  = line_reg;
        cur.head  = head_reg;
        cur.vo    = vo_reg;
        cur.cnt   = cnt_reg;
        cur.state = state_reg;
        cur.ret   = ret_reg;

        go   = !m_valid_reg || m_tready;
        st   = cur;
        fire = 1'b0;

        unique case (state_reg)
            tcc_pkg::SEQ_IDLE: begin
                if (item_valid && !norm.busy) begin
                    fire = go;
                    st   = start_step(cur, item, cfg);
                end
            end
            tcc_pkg::SEQ_ADV: begin
                fire = go;
                st   = advance_step(cur, cnt_reg - 1'b1, cfg);
            end
            tcc_pkg::SEQ_DRAW: begin
                fire    = go;
                st.emit = 1'b1;
                st.res  = draw_res(vo_reg, head_reg, cfg,
                                   (ret_reg == RET_DONE) || (ret_reg == RET_ADV && cnt_reg == '0));
                case (ret_reg)
                    RET_CURSOR: st.state = tcc_pkg::SEQ_CURSOR;
                    RET_ADV:    st.state = (cnt_reg != '0) ? tcc_pkg::SEQ_ADV : tcc_pkg::SEQ_IDLE;
                    default:    st.state = tcc_pkg::SEQ_IDLE;
                endcase
                st.ret = RET_DONE;
            end
            tcc_pkg::SEQ_CURSOR: begin
                fire     = go;
                st.emit  = 1'b1;
                st.res   = make_res(tcc_pkg::K_CURSOR, '0, col_reg, line_reg, '0, cnt_reg == '0);
                st.state = (cnt_reg != '0) ? tcc_pkg::SEQ_ADV : tcc_pkg::SEQ_IDLE;
            end
            default: ;
        endcase

        take = fire && (state_reg == tcc_pkg::SEQ_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tcc_pkg::SEQ_IDLE;
            ret_reg     <= RET_DONE;
            cnt_reg     <= '0;
            col_reg     <= '0;
            line_reg    <= '0;
            head_reg    <= '0;
            vo_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                state_reg <= st.state;
                ret_reg   <= st.ret;
                cnt_reg   <= st.cnt;
                col_reg   <= st.col;
                line_reg  <= st.line;
                head_reg  <= st.head;
                vo_reg    <= st.vo;
            end else if (norm.done) begin
                head_reg <= norm.rem;
            end
            if (go) begin
                m_valid_reg <= fire && st.emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            res_reg <= st.res;
        end
    end

    assign m_valid = m_valid_reg;
    assign res     = res_reg;
    assign head    = head_reg;

endmodule

FILE: rtl/core/tcc_checker.sv
// Port-level checks on the command stream of the console engine, bound to the top level.
`timescale 1ns / 1ps

module tcc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tcc_pkg::TDATA_W-1:0]    m_tdata,
    input logic [tcc_pkg::KIND_W-1:0]     m_tuser,
    input logic                           m_tlast
);

    // A stalled command stays offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("command withdrawn while stalled");

    // A stalled command keeps its contents.
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("command changed while stalled");

    // Only glyph commands carry a character.
    a_glyph_field: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != tcc_pkg::K_GLYPH) |-> (m_tdata[7:0] == '0))
        else $error("character field set on a non-glyph command");

    // Nothing is offered in the first cycle after reset is released.
    a_reset_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_tvalid)
        else $error("command offered straight after reset");

endmodule

bind text_console_cursor_scroll tcc_checker u_tcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
